// ===== sv/rmd_pkg.sv =====
// Shared types and constants for the rational multiply/divide/normalize block.
package rmd_pkg;

    localparam int unsigned MAG_W  = 32;
    localparam int unsigned PROD_W = 64;
    localparam int unsigned CNT_W  = 7;

    typedef enum logic [1:0] {
        ACT_NORM = 2'd0,
        ACT_MUL  = 2'd1,
        ACT_DIV  = 2'd2,
        ACT_RSV  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_RSV      = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_CHECK,
        S_TWOS,
        S_ODDX,
        S_LOOP,
        S_DIVN,
        S_DIVD,
        S_FINISH,
        S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic mul_step;
        logic twos_step;
        logic oddx_step;
        logic loop_step;
        logic div_start;
        logic div_sel_den;
        logic div_step;
        logic div_store;
        logic finish;
    } rmd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic mul_done;
        logic bad_den;
        logic zero_num;
        logic both_even;
        logic x_even;
        logic y_zero;
        logic div_done;
    } rmd_sts_t;

endpackage

// ===== sv/rmd_ctrl.sv =====
// Controller state machine for the rational multiply/divide/normalize block.
module rmd_ctrl
    import rmd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output rmd_cmd_t cmd,
    input  rmd_sts_t sts
);

    state_t state_reg, state_next;

    // hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // sequence the steps of one item
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul_step = 1'b1;
                if (sts.mul_done) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts.bad_den || sts.zero_num) begin
                    state_next = S_FINISH;
                end else begin
                    state_next = S_TWOS;
                end
            end
            S_TWOS: begin
                if (sts.both_even) begin
                    cmd.twos_step = 1'b1;
                end else begin
                    state_next = S_ODDX;
                end
            end
            S_ODDX: begin
                if (sts.x_even) begin
                    cmd.oddx_step = 1'b1;
                end else begin
                    state_next = S_LOOP;
                end
            end
            S_LOOP: begin
                if (sts.y_zero) begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVN;
                end else begin
                    cmd.loop_step = 1'b1;
                end
            end
            S_DIVN: begin
                cmd.div_step = 1'b1;
                if (sts.div_done) begin
                    cmd.div_store = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVD;
                end
            end
            S_DIVD: begin
                cmd.div_step    = 1'b1;
                cmd.div_sel_den = 1'b1;
                if (sts.div_done) begin
                    cmd.div_store = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_FINISH: begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // a new item is only taken with no result pending
    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready while result pending");
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> state_reg == S_IDLE) else $error("load outside idle");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");

endmodule

// ===== sv/rmd_dp.sv =====
// Datapath: magnitudes, shift-add products, binary gcd and restoring dividers.
module rmd_dp
    import rmd_pkg::*;
#(
    parameter int unsigned WIDTH = 32
) (
    input  logic                     aclk,
    input  logic [1:0]               s_action,
    input  logic signed [MAG_W-1:0]  s_a_num,
    input  logic signed [MAG_W-1:0]  s_a_den,
    input  logic signed [MAG_W-1:0]  s_b_num,
    input  logic signed [MAG_W-1:0]  s_b_den,
    input  rmd_cmd_t                 cmd,
    output rmd_sts_t                 sts,
    output logic signed [MAG_W-1:0]  m_res_num,
    output logic [MAG_W-2:0]         m_res_den,
    output logic [1:0]               m_status
);

    localparam logic [PROD_W-1:0] LIM = PROD_W'(1) << (WIDTH - 1);

    logic [MAG_W-1:0]  mcn_reg, mln_reg, mcd_reg, mld_reg;
    logic [PROD_W-1:0] nmag_reg, dmag_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              neg_reg, bad_reg;
    logic [PROD_W-1:0] x_reg, y_reg;
    logic [CNT_W-1:0]  k_reg;
    logic [PROD_W-1:0] g_reg;
    logic [PROD_W-1:0] q_reg, r_reg;
    logic [PROD_W-1:0] qn_reg, qd_reg;
    logic signed [MAG_W-1:0] rn_reg;
    logic [MAG_W-2:0]  rd_reg;
    logic [1:0]        st_reg;

    logic [MAG_W-1:0]  an_m, ad_m, bn_m, bd_m;
    logic              sa, sb, sc, sd;
    action_t           act;
    logic [PROD_W-1:0] yh, ymin, ymax, rsh;
    logic              ovf;

    function automatic logic [MAG_W-1:0] mag(input logic [MAG_W-1:0] v);
        return v[MAG_W-1] ? (~v + 1'b1) : v;
    endfunction

    assign act  = action_t'(s_action);
    assign an_m = mag(s_a_num);
    assign ad_m = mag(s_a_den);
    assign bn_m = mag(s_b_num);
    assign bd_m = mag(s_b_den);
    assign sa   = s_a_num[MAG_W-1];
    assign sb   = s_a_den[MAG_W-1];
    assign sc   = s_b_num[MAG_W-1];
    assign sd   = s_b_den[MAG_W-1];

    // subtract step: strip y's trailing zero then order and subtract
    assign yh   = y_reg[0] ? y_reg : (y_reg >> 1);
    assign ymin = (x_reg > yh) ? yh : x_reg;
    assign ymax = (x_reg > yh) ? x_reg : yh;
    assign rsh  = {r_reg[PROD_W-2:0], q_reg[PROD_W-1]};

    always_ff @(posedge aclk) begin
        // capture the item and choose multiplicand pairs
        if (cmd.load) begin
            unique case (act)
                ACT_MUL: begin
                    mcn_reg <= an_m; mln_reg <= bn_m;
                    mcd_reg <= ad_m; mld_reg <= bd_m;
                    neg_reg <= sa ^ sc ^ sb ^ sd;
                    bad_reg <= (ad_m == '0) || (bd_m == '0);
                end
                ACT_DIV: begin
                    mcn_reg <= an_m; mln_reg <= bd_m;
                    mcd_reg <= ad_m; mld_reg <= bn_m;
                    neg_reg <= sa ^ sd ^ sb ^ sc;
                    bad_reg <= (ad_m == '0) || (bd_m == '0) || (bn_m == '0);
                end
                ACT_NORM, ACT_RSV: begin
                    mcn_reg <= an_m; mln_reg <= MAG_W'(1);
                    mcd_reg <= ad_m; mld_reg <= MAG_W'(1);
                    neg_reg <= sa ^ sb;
                    bad_reg <= (ad_m == '0);
                end
                default: ;
            endcase
            nmag_reg <= '0;
            dmag_reg <= '0;
            cnt_reg  <= '0;
        end
        // shift-add multiply, one multiplier bit per cycle
        if (cmd.mul_step) begin
            nmag_reg <= (nmag_reg << 1)
                + (mln_reg[MAG_W-1] ? PROD_W'(mcn_reg) : '0);
            dmag_reg <= (dmag_reg << 1)
                + (mld_reg[MAG_W-1] ? PROD_W'(mcd_reg) : '0);
            mln_reg  <= mln_reg << 1;
            mld_reg  <= mld_reg << 1;
            cnt_reg  <= cnt_reg + 1'b1;
            x_reg    <= '0;
        end
        if (sts.mul_done && cmd.mul_step) begin
            k_reg <= '0;
        end
        // gcd working copies loaded on first check
        if (!cmd.mul_step && !cmd.twos_step && !cmd.oddx_step && !cmd.loop_step
            && x_reg == '0 && !cmd.load) begin
            x_reg <= nmag_reg;
            y_reg <= dmag_reg;
        end
        if (cmd.twos_step) begin
            x_reg <= x_reg >> 1;
            y_reg <= y_reg >> 1;
            k_reg <= k_reg + 1'b1;
        end
        if (cmd.oddx_step) begin
            x_reg <= x_reg >> 1;
        end
        if (cmd.loop_step) begin
            if (!y_reg[0]) begin
                y_reg <= y_reg >> 1;
            end else begin
                x_reg <= ymin;
                y_reg <= ymax - ymin;
            end
        end
        // restoring divide by g, one quotient bit per cycle
        if (cmd.div_start) begin
            cnt_reg <= '0;
            r_reg   <= '0;
            if (cmd.div_store) begin
                q_reg <= dmag_reg;
            end else begin
                q_reg <= nmag_reg;
                g_reg <= x_reg << k_reg;
            end
        end else if (cmd.div_step) begin
            r_reg   <= (rsh >= g_reg) ? rsh - g_reg : rsh;
            q_reg   <= {q_reg[PROD_W-2:0], rsh >= g_reg};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.div_store) begin
            if (cmd.div_sel_den) begin
                qd_reg <= {q_reg[PROD_W-2:0], rsh >= g_reg};
            end else begin
                qn_reg <= {q_reg[PROD_W-2:0], rsh >= g_reg};
            end
        end
        // form the result and status
        if (cmd.finish) begin
            if (bad_reg) begin
                st_reg <= ST_ZERO_DEN; rn_reg <= '0; rd_reg <= '0;
            end else if (nmag_reg == '0) begin
                st_reg <= ST_OK; rn_reg <= '0; rd_reg <= (MAG_W-1)'(1);
            end else if (ovf) begin
                st_reg <= ST_OVERFLOW; rn_reg <= '0; rd_reg <= '0;
            end else begin
                st_reg <= ST_OK;
                rn_reg <= neg_reg ? -$signed(qn_reg[MAG_W-1:0])
                                  : $signed(qn_reg[MAG_W-1:0]);
                rd_reg <= qd_reg[MAG_W-2:0];
            end
        end
    end

    assign ovf = (qd_reg > LIM - 1'b1) || (qn_reg > (neg_reg ? LIM : LIM - 1'b1));

    assign sts.mul_done  = (cnt_reg == CNT_W'(MAG_W - 1));
    assign sts.bad_den   = bad_reg;
    assign sts.zero_num  = (nmag_reg == '0);
    assign sts.both_even = !x_reg[0] && !y_reg[0];
    assign sts.x_even    = !x_reg[0];
    assign sts.y_zero    = (y_reg == '0);
    assign sts.div_done  = (cnt_reg == CNT_W'(PROD_W - 1));

    assign m_res_num = rn_reg;
    assign m_res_den = rd_reg;
    assign m_status  = st_reg;

endmodule

// ===== sv/rational_mul_div_normalize.sv =====
// Top level: reduced signed fraction normalize, multiply and divide.
//
// Input item (s_valid/s_ready): action plus fractions a and b. Result item
// (m_valid/m_ready): reduced numerator, denominator (positive unless the status is an error) and status.
// One item is worked at a time. After the accepting edge the block forms
// the shift-add products, makes a check, runs the binary gcd (twos removal,
// odd x, then the halve-and-subtract loop on 64-bit magnitudes), divides
// numerator and denominator by the gcd with restoring division and then
// finishes, before m_valid rises. Zero numerators and zero denominators
// skip gcd and division. The next item is taken in the cycle after the
// result leaves. Reset returns the controller to idle with s_ready high and
// no result pending. A result waits in its register while m_ready is low;
// s_ready stays low until it is taken.
module rational_mul_div_normalize
    import rmd_pkg::*;
#(
    parameter int unsigned WIDTH = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_action,
    input  logic signed [MAG_W-1:0] s_a_num,
    input  logic signed [MAG_W-1:0] s_a_den,
    input  logic signed [MAG_W-1:0] s_b_num,
    input  logic signed [MAG_W-1:0] s_b_den,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [MAG_W-1:0] m_res_num,
    output logic [MAG_W-2:0]        m_res_den,
    output logic [1:0]              m_status
);

    rmd_cmd_t cmd;
    rmd_sts_t sts;

    rmd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    rmd_dp #(.WIDTH(WIDTH)) u_dp (
        .aclk      (aclk),
        .s_action  (s_action),
        .s_a_num   (s_a_num),
        .s_a_den   (s_a_den),
        .s_b_num   (s_b_num),
        .s_b_den   (s_b_den),
        .cmd       (cmd),
        .sts       (sts),
        .m_res_num (m_res_num),
        .m_res_den (m_res_den),
        .m_status  (m_status)
    );

endmodule
